@@ rtl/core/csbi_pkg.sv @@
// csbi_pkg: shared types and constants of the counting sort bucket index
// holds item structs, command and status codes, controller state and link structs
// no dependencies
`timescale 1ns / 1ps

package csbi_pkg;

   // default sizes of the stores
   localparam int NUM_KEYS_DEF      = 4096;
   localparam int MAX_HITS_DEF      = 65536;
   localparam int CHAIN_BITS_DEF    = 16;
   localparam int POSITION_BITS_DEF = 16;

   // keys_in_use register
   localparam int             KEYS_IN_USE_W   = 13;
   localparam logic [12:0]    KEYS_IN_USE_RST = 13'd4096;

   // commands
   localparam logic [2:0] CMD_COUNT  = 3'd0;
   localparam logic [2:0] CMD_BUILD  = 3'd1;
   localparam logic [2:0] CMD_PLACE  = 3'd2;
   localparam logic [2:0] CMD_LOOKUP = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   // result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_PHASE    = 2'd1;
   localparam logic [1:0] STS_OVERFLOW = 2'd2;
   localparam logic [1:0] STS_RANGE    = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [11:0] key;
      logic [15:0] chain_id;
      logic [15:0] position;
      logic [15:0] hit_index;
   } req_type;

   typedef struct packed {
      logic [16:0] range_begin;
      logic [16:0] range_end;
      logic [15:0] hit_chain;
      logic [15:0] hit_position;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      CS_INIT,
      CS_IDLE,
      CS_EXEC,
      CS_BUILD,
      CS_DRAIN,
      CS_CLEAR
   } ctl_state_type;

   typedef enum logic {
      PH_COUNTING,
      PH_BUILT
   } phase_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // take the request into the datapath
      logic exec;         // single-item operation cycle, result out
      logic walk_start;   // begin the prefix-sum walk
      logic walk;         // issue one key of the walk
      logic sweep_start;  // begin zeroing the tallies
      logic sweep;        // zero one tally entry
      logic done;         // emit an ok result for build or clear
      logic built;        // index is in the built phase
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_last;
      logic sweep_last;
   } dp_sts_type;

endpackage

@@ rtl/core/csbi_ctrl.sv @@
// csbi_ctrl: sequencing state machine of the counting sort bucket index
// owns the phase; drives the datapath through ctl_cmd_type; uses csbi_pkg
`timescale 1ns / 1ps

module csbi_ctrl
   import csbi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_command,
   input  dp_sts_type  dp_sts,
   output ctl_cmd_type ctl_cmd,
   output logic        busy
);

   ctl_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_INIT;
         phase_ff <= PH_COUNTING;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ctl_cmd  = '0;
      ctl_cmd.built = (phase_ff == PH_BUILT);
      unique case (state_ff)
         CS_INIT: begin
            ctl_cmd.sweep = 1'b1;
            if (dp_sts.sweep_last) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            if (start) begin
               ctl_cmd.capture = 1'b1;
               if (req_command == CMD_CLEAR) begin
                  ctl_cmd.sweep_start = 1'b1;
                  state_in = CS_CLEAR;
               end else if (req_command == CMD_BUILD && phase_ff == PH_COUNTING) begin
                  ctl_cmd.walk_start = 1'b1;
                  state_in = CS_BUILD;
               end else begin
                  state_in = CS_EXEC;
               end
            end
         end
         CS_EXEC: begin
            ctl_cmd.exec = 1'b1;
            state_in = CS_IDLE;
         end
         CS_BUILD: begin
            ctl_cmd.walk = 1'b1;
            if (dp_sts.walk_last) begin
               state_in = CS_DRAIN;
            end
         end
         CS_DRAIN: begin
            // last offset is written this cycle
            ctl_cmd.done = 1'b1;
            phase_in = PH_BUILT;
            state_in = CS_IDLE;
         end
         CS_CLEAR: begin
            ctl_cmd.sweep = 1'b1;
            if (dp_sts.sweep_last) begin
               ctl_cmd.done = 1'b1;
               phase_in = PH_COUNTING;
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_INIT;
         end
      endcase
   end

   assign busy = (state_ff != CS_IDLE);

endmodule

@@ rtl/core/csbi_datapath.sv @@
// csbi_datapath: tally/offset, cursor and hit memories, counters and result register
// steered by csbi_ctrl through ctl_cmd_type; uses csbi_pkg
`timescale 1ns / 1ps

module csbi_datapath
   import csbi_pkg::*;
#(
   parameter int NUM_KEYS      = NUM_KEYS_DEF,
   parameter int MAX_HITS      = MAX_HITS_DEF,
   parameter int CHAIN_BITS    = CHAIN_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_cmd_type              ctl_cmd,
   output dp_sts_type               dp_sts,
   input  req_type                  req_payload,
   input  logic                     csr_write_en,
   input  logic [KEYS_IN_USE_W-1:0] csr_write_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_payload
);

   localparam int KEY_AW = $clog2(NUM_KEYS + 1);
   localparam int CUR_AW = $clog2(NUM_KEYS);
   localparam int HIT_AW = $clog2(MAX_HITS);
   localparam int OFS_W  = $clog2(MAX_HITS + 1);
   localparam int HIT_W  = CHAIN_BITS + POSITION_BITS;

   // memories
   logic [OFS_W-1:0] bucket_mem [0:NUM_KEYS];
   logic [OFS_W-1:0] cursor_mem [0:NUM_KEYS-1];
   logic [HIT_W-1:0] hit_mem    [0:MAX_HITS-1];

   req_type                  req_ff;
   logic [KEYS_IN_USE_W-1:0] keys_in_use_ff;
   logic [OFS_W-1:0]         total_ff;
   logic [KEY_AW-1:0]        ptr_ff;
   logic [KEY_AW-1:0]        pd_ff;
   logic                     wv_ff;
   logic [OFS_W-1:0]         run_ff;
   logic [OFS_W-1:0]         bkt_rda_ff, bkt_rdb_ff, cur_rd_ff;
   logic [HIT_W-1:0]         hit_rd_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic [KEY_AW-1:0] bkt_ra, bkt_rb, bkt_wa;
   logic [OFS_W-1:0]  bkt_wd, walk_sum;
   logic              bkt_we;
   logic [CUR_AW-1:0] cur_ra;
   logic [HIT_AW-1:0] hit_ra;
   logic              key_ok, cnt_go, place_go;

   // read addresses come straight from the ports at accept, from the walk pointer in build
   assign bkt_ra   = ctl_cmd.walk ? ptr_ff + KEY_AW'(1)
                                  : KEY_AW'(req_payload.key) + KEY_AW'(1);
   assign bkt_rb   = KEY_AW'(req_payload.key);
   assign cur_ra   = CUR_AW'(req_payload.key);
   assign hit_ra   = HIT_AW'(req_payload.hit_index);
   assign walk_sum = bkt_rda_ff + run_ff;

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bucket_mem[bkt_wa] <= bkt_wd;
      end
      bkt_rda_ff <= bucket_mem[bkt_ra];
      bkt_rdb_ff <= bucket_mem[bkt_rb];
   end

   always_ff @(posedge clock) begin
      if (wv_ff) begin
         cursor_mem[pd_ff[CUR_AW-1:0]] <= run_ff;
      end else if (ctl_cmd.exec && place_go) begin
         cursor_mem[CUR_AW'(req_ff.key)] <= cur_rd_ff + OFS_W'(1);
      end
      cur_rd_ff <= cursor_mem[cur_ra];
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.exec && place_go) begin
         hit_mem[cur_rd_ff[HIT_AW-1:0]] <= {CHAIN_BITS'(req_ff.chain_id),
                                            POSITION_BITS'(req_ff.position)};
      end
      hit_rd_ff <= hit_mem[hit_ra];
   end

   // tally write port: clearing sweep, prefix-sum write, count increment
   always_comb begin
      bkt_we = 1'b0;
      bkt_wa = ptr_ff;
      bkt_wd = '0;
      if (ctl_cmd.sweep) begin
         bkt_we = 1'b1;
      end else if (wv_ff) begin
         bkt_we = 1'b1;
         bkt_wa = pd_ff + KEY_AW'(1);
         bkt_wd = walk_sum;
      end else if (ctl_cmd.exec && cnt_go) begin
         bkt_we = 1'b1;
         bkt_wa = KEY_AW'(req_ff.key) + KEY_AW'(1);
         bkt_wd = bkt_rda_ff + OFS_W'(1);
      end
   end

   // single-item decode and status
   always_comb begin
      key_ok   = (KEYS_IN_USE_W'(req_ff.key) < keys_in_use_ff)
                 && (32'(req_ff.key) < 32'(NUM_KEYS));
      cnt_go   = 1'b0;
      place_go = 1'b0;
      rsp_in   = '0;
      rsp_in.status = STS_OK;
      unique case (req_ff.command)
         CMD_COUNT: begin
            if (ctl_cmd.built) begin
               rsp_in.status = STS_PHASE;
            end else if (!key_ok) begin
               rsp_in.status = STS_RANGE;
            end else if (32'(total_ff) >= 32'(MAX_HITS)) begin
               rsp_in.status = STS_OVERFLOW;
            end else begin
               cnt_go = 1'b1;
            end
         end
         CMD_PLACE: begin
            if (!ctl_cmd.built) begin
               rsp_in.status = STS_PHASE;
            end else if (!key_ok) begin
               rsp_in.status = STS_RANGE;
            end else if (cur_rd_ff >= bkt_rda_ff || 32'(cur_rd_ff) >= 32'(MAX_HITS)) begin
               rsp_in.status = STS_OVERFLOW;
            end else begin
               place_go = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            if (!ctl_cmd.built) begin
               rsp_in.status = STS_PHASE;
            end else if (!key_ok) begin
               rsp_in.status = STS_RANGE;
            end else begin
               rsp_in.range_begin = 17'(bkt_rdb_ff);
               rsp_in.range_end   = 17'(bkt_rda_ff);
            end
         end
         CMD_READ: begin
            if (!ctl_cmd.built) begin
               rsp_in.status = STS_PHASE;
            end else if (32'(req_ff.hit_index) >= 32'(total_ff)
                         || 32'(req_ff.hit_index) >= 32'(MAX_HITS)) begin
               rsp_in.status = STS_RANGE;
            end else begin
               rsp_in.hit_chain    = 16'(hit_rd_ff[HIT_W-1:POSITION_BITS]);
               rsp_in.hit_position = 16'(hit_rd_ff[POSITION_BITS-1:0]);
            end
         end
         default: begin
            // build after build, unknown codes
            rsp_in.status = STS_PHASE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         req_ff <= req_payload;
      end
      pd_ff <= ptr_ff;
      if (ctl_cmd.walk_start) begin
         run_ff <= '0;
      end else if (wv_ff) begin
         run_ff <= walk_sum;
      end
      if (ctl_cmd.exec) begin
         rsp_ff <= rsp_in;
      end else if (ctl_cmd.done) begin
         rsp_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_in_use_ff <= KEYS_IN_USE_RST;
         total_ff       <= '0;
         ptr_ff         <= '0;
         wv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            keys_in_use_ff <= csr_write_data;
         end
         if (ctl_cmd.sweep_start) begin
            total_ff <= '0;
         end else if (ctl_cmd.exec && cnt_go) begin
            total_ff <= total_ff + OFS_W'(1);
         end
         if (ctl_cmd.walk_start || ctl_cmd.sweep_start) begin
            ptr_ff <= '0;
         end else if (ctl_cmd.walk || ctl_cmd.sweep) begin
            ptr_ff <= ptr_ff + KEY_AW'(1);
         end
         wv_ff        <= ctl_cmd.walk;
         rsp_valid_ff <= ctl_cmd.exec || ctl_cmd.done;
      end
   end

   assign dp_sts.walk_last  = (ptr_ff == KEY_AW'(NUM_KEYS - 1));
   assign dp_sts.sweep_last = (ptr_ff == KEY_AW'(NUM_KEYS));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/counting_sort_bucket_index.sv @@
// counting_sort_bucket_index: top level of the counting sort hit index
// instantiates csbi_ctrl and csbi_datapath; uses csbi_pkg
`timescale 1ns / 1ps
// usage
//   an item is taken on a clock edge with start high and busy low; req_payload carries
//   command, key, chain_id, position and hit_index
//   every item gives exactly one result: rsp_valid is high for one cycle with rsp_payload
//   the receiver cannot stall, so results must be taken in the cycle they appear
//   csr_write_en / csr_write_data write keys_in_use; write only while idle
// timing
//   count, place, lookup, read and refused items: the memories are read into registers
//   at accept, then the execute state writes the result register; the next item is
//   taken at the edge that takes the result
//   build: the prefix-sum walk does one key per cycle on the offset memory port, then
//   the drain state writes the last offset and gives the result
//   clear: zeroing one offset entry per cycle
// reset
//   after reset busy stays high while the offset memory is zeroed; no result
//   is given for it; keys_in_use returns to 4096
//   cursor and hit memories are not cleared; they are filled by build and place

module counting_sort_bucket_index
   import csbi_pkg::*;
#(
   parameter int NUM_KEYS      = NUM_KEYS_DEF,
   parameter int MAX_HITS      = MAX_HITS_DEF,
   parameter int CHAIN_BITS    = CHAIN_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   // item channel
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_payload,
   // result channel
   output logic                     rsp_valid,
   output rsp_type                  rsp_payload,
   // keys_in_use register
   input  logic                     csr_write_en,
   input  logic [KEYS_IN_USE_W-1:0] csr_write_data
);

   ctl_cmd_type ctl_cmd;
   dp_sts_type  dp_sts;

   // sequencer: decides per item between one-shot execute, walk and sweep
   csbi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_payload.command),
      .dp_sts      (dp_sts),
      .ctl_cmd     (ctl_cmd),
      .busy        (busy)
   );

   // memories, counters and the result register
   csbi_datapath #(
      .NUM_KEYS      (NUM_KEYS),
      .MAX_HITS      (MAX_HITS),
      .CHAIN_BITS    (CHAIN_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl_cmd        (ctl_cmd),
      .dp_sts         (dp_sts),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload)
   );

endmodule

@@ bench/csbi_checker.sv @@
// csbi_checker: result checker for the counting sort bucket index bench
// predicts each accepted item's result and compares it with the block's output; uses csbi_pkg
`timescale 1ns / 1ps

module csbi_checker
   import csbi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  req_type                  req_payload,
   input  logic                     rsp_valid,
   input  rsp_type                  rsp_payload,
   input  logic                     csr_write_en,
   input  logic [KEYS_IN_USE_W-1:0] csr_write_data,
   output int                       fail_count,
   output int                       pending,
   output int                       checked
);

   logic [KEYS_IN_USE_W-1:0] key_count_limit;
   logic [16:0]              bucket_start [0:NUM_KEYS_DEF];
   logic [16:0]              fill_cursor [0:NUM_KEYS_DEF-1];
   logic [31:0]              hit_slots [0:MAX_HITS_DEF-1];
   logic [16:0]              hit_total;
   phase_type                index_phase;
   rsp_type                  awaited [$];

   function automatic void clear_tallies();
      for (int i = 0; i <= NUM_KEYS_DEF; i++) bucket_start[i] = '0;
      hit_total = '0;
      index_phase = PH_COUNTING;
   endfunction

   function automatic string fields(input rsp_type r);
      return $sformatf("begin=%0d end=%0d chain=%h pos=%h status=%0d",
                       r.range_begin, r.range_end, r.hit_chain, r.hit_position, r.status);
   endfunction

   // expected result of one item, updating the predicted index on the way
   function automatic rsp_type index_response(input req_type item);
      rsp_type     r;
      logic        key_ok;
      logic [16:0] slot;
      r = '0;
      key_ok = item.key < key_count_limit;
      case (item.command)
         CMD_COUNT: begin
            if (index_phase != PH_COUNTING) r.status = STS_PHASE;
            else if (!key_ok) r.status = STS_RANGE;
            else if (hit_total >= MAX_HITS_DEF) r.status = STS_OVERFLOW;
            else begin
               bucket_start[item.key + 1] = bucket_start[item.key + 1] + 1'b1;
               hit_total = hit_total + 1'b1;
            end
         end
         CMD_BUILD: begin
            if (index_phase != PH_COUNTING) r.status = STS_PHASE;
            else begin
               bucket_start[0] = '0;
               for (int i = 0; i < NUM_KEYS_DEF; i++) begin
                  bucket_start[i + 1] = bucket_start[i + 1] + bucket_start[i];
                  fill_cursor[i] = bucket_start[i];
               end
               index_phase = PH_BUILT;
            end
         end
         CMD_PLACE: begin
            if (index_phase != PH_BUILT) r.status = STS_PHASE;
            else if (!key_ok) r.status = STS_RANGE;
            else if (fill_cursor[item.key] >= bucket_start[item.key + 1] ||
                     fill_cursor[item.key] >= MAX_HITS_DEF)
               r.status = STS_OVERFLOW;
            else begin
               slot = fill_cursor[item.key];
               hit_slots[slot[15:0]] = {item.chain_id, item.position};
               fill_cursor[item.key] = slot + 1'b1;
            end
         end
         CMD_LOOKUP: begin
            if (index_phase != PH_BUILT) r.status = STS_PHASE;
            else if (!key_ok) r.status = STS_RANGE;
            else begin
               r.range_begin = bucket_start[item.key];
               r.range_end = bucket_start[item.key + 1];
            end
         end
         CMD_READ: begin
            if (index_phase != PH_BUILT) r.status = STS_PHASE;
            else if (item.hit_index >= hit_total) r.status = STS_RANGE;
            else {r.hit_chain, r.hit_position} = hit_slots[item.hit_index];
         end
         CMD_CLEAR: clear_tallies();
         default: r.status = STS_PHASE;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         key_count_limit = KEYS_IN_USE_RST;
         clear_tallies();
         awaited.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (csr_write_en) key_count_limit = csr_write_data;
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, got %s", $time, fields(rsp_payload));
            end else begin
               want = awaited.pop_front();
               checked++;
               if (rsp_payload !== want) begin
                  fail_count++;
                  $display("%0t: result %0d mismatch, expected %s", $time, checked, fields(want));
                  $display("%0t: result %0d mismatch, actual   %s", $time, checked,
                           fields(rsp_payload));
               end
            end
         end
         if (start && !busy) awaited.push_back(index_response(req_payload));
      end
      pending = awaited.size();
   end

endmodule

@@ bench/tb_counting_sort_bucket_index.sv @@
// tb_counting_sort_bucket_index: stimulus and verdict for the counting sort bucket index
// drives counting_sort_bucket_index and watches it through csbi_checker; uses csbi_pkg
`timescale 1ns / 1ps

module tb_counting_sort_bucket_index;
   import csbi_pkg::*;

   // commands with no meaning, refused as wrong phase
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_payload;
   logic                     rsp_valid;
   rsp_type                  rsp_payload;
   logic                     csr_write_en;
   logic [KEYS_IN_USE_W-1:0] csr_write_data;
   int                       fail_count;
   int                       pending;
   int                       checked;

   // light view of the index state, only what shaping the stimulus needs
   int          key_limit;      // min(keys_in_use, key space)
   int          tally_total;    // counts taken since the last clear
   bit          index_built;
   logic [11:0] round_keys [$]; // every key counted this round
   logic [11:0] unplaced [$];   // one entry per counted hit not yet placed
   int          pool_base;
   int          pool_span;
   bit          steady;         // no gaps between items
   int          items_sent;
   int          rounds_run;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   counting_sort_bucket_index DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   csbi_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked)
   );

   // watchdog, several times the slowest legal run
   initial begin
      #12_000_000;
      $display("[counting_sort_bucket_index] ERROR");
      $finish;
   end

   // one item with the given command and key, other fields random
   function automatic req_type keyed(input logic [2:0] cmd, input logic [11:0] k);
      req_type it;
      it.command = cmd;
      it.key = k;
      it.chain_id = 16'($urandom_range(65535, 0));
      it.position = 16'($urandom_range(65535, 0));
      it.hit_index = 16'($urandom_range(65535, 0));
      return it;
   endfunction

   // a slot to read that never touches a slot not yet placed
   function automatic logic [15:0] read_slot();
      if (!index_built) return 16'($urandom_range(65535, 0));
      if (unplaced.size() == 0 && tally_total > 0 && $urandom_range(3, 0) != 0)
         return 16'($urandom_range(tally_total - 1, 0));
      return 16'($urandom_range(65535, tally_total));
   endfunction

   // any command, any key; no clear, and no build while still counting
   function automatic req_type noise_item();
      req_type it;
      it = keyed(3'($urandom_range(7, 0)), 12'($urandom_range(4095, 0)));
      if (it.command == CMD_CLEAR || (it.command == CMD_BUILD && !index_built))
         it.command = CMD_LOOKUP;
      if (it.command == CMD_READ) it.hit_index = read_slot();
      return it;
   endfunction

   function automatic logic [11:0] count_key();
      if (key_limit == 0) return 12'($urandom_range(4095, 0));
      return 12'(pool_base + $urandom_range(pool_span - 1, 0));
   endfunction

   // hand one item over: random gap, then hold start until the block takes it
   task automatic issue(input req_type item);
      int gap;
      gap = steady ? 0 : $urandom_range(4, 0);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      // follow the phase and the tallies
      case (item.command)
         CMD_COUNT: begin
            if (!index_built && item.key < key_limit && tally_total < MAX_HITS_DEF) begin
               tally_total++;
               round_keys.push_back(item.key);
               unplaced.push_back(item.key);
            end
         end
         CMD_BUILD: index_built = 1'b1;
         CMD_CLEAR: begin
            index_built = 1'b0;
            tally_total = 0;
            round_keys.delete();
            unplaced.delete();
         end
         default: ;
      endcase
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_keys(input logic [KEYS_IN_USE_W-1:0] value);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      key_limit = (value > NUM_KEYS_DEF) ? NUM_KEYS_DEF : value;
   endtask

   // one full cycle of the index: count, build, place every hit, query, clear
   task automatic run_round();
      req_type it;
      int      pick;
      // register extremes first, then a mix
      case (rounds_run)
         0: write_keys(13'd1);
         1: write_keys('1);
         2: write_keys('0);
         3: write_keys(KEYS_IN_USE_RST);
         default: begin
            if ($urandom_range(1, 0) == 1) begin
               case ($urandom_range(3, 0))
                  0: write_keys(13'($urandom_range(64, 2)));
                  1: write_keys(13'($urandom_range(8191, 4097)));
                  2: write_keys(13'($urandom_range(4095, 65)));
                  default: write_keys(KEYS_IN_USE_RST);
               endcase
            end
         end
      endcase
      steady = ($urandom_range(3, 0) == 0);
      // clustered keys give deep buckets, spread keys give wide ones
      if (key_limit > 0) begin
         if ($urandom_range(1, 0) == 1) pool_span = (key_limit < 8) ? key_limit : 8;
         else pool_span = key_limit;
         pool_base = $urandom_range(key_limit - pool_span, 0);
      end

      // counting phase
      repeat ($urandom_range(48, 1)) begin
         if ($urandom_range(7, 0) == 0) issue(noise_item());
         else issue(keyed(CMD_COUNT, count_key()));
      end
      issue(keyed(CMD_BUILD, 12'($urandom_range(4095, 0))));

      // place each counted hit once, in random order
      while (unplaced.size() > 0) begin
         if ($urandom_range(7, 0) == 0) begin
            issue(noise_item());
         end else begin
            pick = $urandom_range(unplaced.size() - 1, 0);
            issue(keyed(CMD_PLACE, unplaced[pick]));
            unplaced.delete(pick);
         end
         // sender holds off until the block has answered everything
         if ($urandom_range(31, 0) == 0) wait_drained();
      end

      // every slot is filled now: reads, lookups, places into full buckets
      repeat ($urandom_range(40, 15)) begin
         case ($urandom_range(5, 0))
            0, 1: begin
               it = keyed(CMD_READ, 12'($urandom_range(4095, 0)));
               it.hit_index = read_slot();
               issue(it);
            end
            2: begin
               if (round_keys.size() > 0)
                  issue(keyed(CMD_LOOKUP, round_keys[$urandom_range(round_keys.size() - 1, 0)]));
               else
                  issue(noise_item());
            end
            3: issue(keyed(CMD_LOOKUP, 12'($urandom_range(4095, 0))));
            4: issue(keyed(CMD_PLACE, 12'($urandom_range(4095, 0))));
            default: issue(noise_item());
         endcase
      end
      if ($urandom_range(3, 0) == 0) wait_drained();
      issue(keyed(CMD_CLEAR, 12'($urandom_range(4095, 0))));
      rounds_run++;
   endtask

   initial begin : stimulus
      req_type it;
      int      target;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_write_en = 1'b0;
      csr_write_data = KEYS_IN_USE_RST;
      key_limit = NUM_KEYS_DEF;
      tally_total = 0;
      index_built = 1'b0;
      pool_base = 0;
      pool_span = NUM_KEYS_DEF;
      steady = 1'b0;
      items_sent = 0;
      rounds_run = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: everything refused before a build, unknown commands too
      it = keyed(CMD_READ, '0);
      it.hit_index = '0;
      issue(it);
      issue(keyed(CMD_LOOKUP, '0));
      issue(keyed(CMD_PLACE, '0));
      issue(keyed(CMD_SPARE_LO, '1));
      issue(keyed(CMD_SPARE_HI, '0));
      // clear while still counting
      issue(keyed(CMD_COUNT, 12'd7));
      issue(keyed(CMD_CLEAR, '0));
      // two buckets at the ends of the key space
      issue(keyed(CMD_COUNT, '0));
      issue(keyed(CMD_COUNT, '1));
      issue(keyed(CMD_COUNT, '1));
      issue(keyed(CMD_COUNT, '0));
      issue(keyed(CMD_BUILD, '0));
      // build and count once built are wrong phase
      issue(keyed(CMD_BUILD, '0));
      issue(keyed(CMD_COUNT, '0));
      // field extremes on place
      it = keyed(CMD_PLACE, '0);
      it.chain_id = '0;
      it.position = '0;
      issue(it);
      it = keyed(CMD_PLACE, '1);
      it.chain_id = '1;
      it.position = '1;
      issue(it);
      issue(keyed(CMD_PLACE, '0));
      issue(keyed(CMD_PLACE, '1));
      // full bucket, and a bucket that never had room
      issue(keyed(CMD_PLACE, '1));
      issue(keyed(CMD_PLACE, 12'd9));
      issue(keyed(CMD_LOOKUP, '0));
      issue(keyed(CMD_LOOKUP, '1));
      issue(keyed(CMD_LOOKUP, 12'd100));
      // first and last filled slot, then past the end
      it = keyed(CMD_READ, '0);
      it.hit_index = '0;
      issue(it);
      it.hit_index = 16'd3;
      issue(it);
      it.hit_index = 16'd4;
      issue(it);
      it.hit_index = '1;
      issue(it);
      issue(keyed(CMD_CLEAR, '0));

      // random rounds
      target = items_sent + 1700;
      while (items_sent < target) run_round();

      wait_drained();
      repeat (16) @(negedge clock);
      $display("covered %0d items and %0d checked results: directed phase, bucket and slot cases",
               items_sent, checked);
      $display("and %0d random rounds with keys_in_use at 0, 1, 4096, 8191 and between",
               rounds_run);
      if (fail_count == 0 && pending == 0) begin
         $display("[counting_sort_bucket_index] OK");
      end else begin
         $display("[counting_sort_bucket_index] ERROR");
      end
      $finish;
   end

endmodule
